>>> design/ivsa_pkg.sv
// Package for the inverse variance slope accumulator.
// Widths, configuration register indexes, operation codes and the item type.
// No dependencies.
package ivsa_pkg;

  localparam int PIX_W      = 16;
  localparam int ADDR_W     = 16;   // log2 of the pixel store depth
  localparam int PIXELS     = 1 << ADDR_W;
  localparam int FLAG_W     = 10;
  localparam int INTG_W     = 8;
  localparam int SLOPE_W    = 32;
  localparam int UNC_W      = 32;
  localparam int VAR_W      = 2 * UNC_W;
  localparam int WSUM_W     = 64;
  localparam int WT_W       = 48;
  localparam int DIV_W      = 80;   // dividend width: 32-bit magnitude over 48 fraction bits
  localparam int FRAC_B     = 48;
  localparam int IGN_SLOTS  = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_QUICK   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NINT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IGN_CNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT0   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT1   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT2   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT3   = 3'd6;

  localparam logic [WT_W-1:0]   WT_MAX   = {WT_W{1'b1}};
  localparam logic [WT_W-1:0]   ONE_Q16  = 48'd65536;
  localparam logic [WSUM_W-1:0] WSUM_MAX = {1'b0, {(WSUM_W-1){1'b1}}};
  localparam logic [WSUM_W-1:0] WSUM_MIN = {1'b1, {(WSUM_W-1){1'b0}}};

  // what the back end does with a request
  typedef enum logic [2:0] {
    OP_NOP,     // read and report only
    OP_COPY_W,  // copy slope, uncertainty and flags
    OP_COPY_Q,  // copy slope only
    OP_QADD,    // plain sum and count
    OP_FLAG,    // merge flags, sums unchanged
    OP_WADD     // merge flags, add weighted terms
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [PIX_W-1:0]   pix;
    logic [FLAG_W-1:0]  flags;
    logic [SLOPE_W-1:0] slope;
    logic [UNC_W-1:0]   unc;
  } item_t;

endpackage

>>> design/ivsa_front.sv
// Front end: configuration registers and request classification.
// Depends on ivsa_pkg.
module ivsa_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ivsa_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ivsa_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic [ivsa_pkg::PIX_W-1:0]         pixel_index_i,
  input  logic [ivsa_pkg::INTG_W-1:0]        integration_index_i,
  input  logic signed [ivsa_pkg::SLOPE_W-1:0] slope_value_i,
  input  logic                               slope_missing_i,
  input  logic [ivsa_pkg::UNC_W-1:0]         slope_uncertainty_i,
  input  logic [ivsa_pkg::FLAG_W-1:0]        quality_flags_i,
  output ivsa_pkg::item_t                    item_o
);

  logic                              quick_q;
  logic [ivsa_pkg::INTG_W-1:0]       nint_q;
  logic [2:0]                        ign_cnt_q;
  logic [ivsa_pkg::INTG_W-1:0]       slot_q [ivsa_pkg::IGN_SLOTS];
  logic [2:0]                        ign_n;
  logic                              ignored;
  logic [ivsa_pkg::INTG_W:0]         intg_p1;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quick_q   <= 1'b0;
      nint_q    <= 8'd1;
      ign_cnt_q <= 3'd0;
      for (int k = 0; k < ivsa_pkg::IGN_SLOTS; k++) slot_q[k] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ivsa_pkg::CFG_QUICK:   quick_q   <= cfg_data_i[0];
        ivsa_pkg::CFG_NINT:    nint_q    <= cfg_data_i;
        ivsa_pkg::CFG_IGN_CNT: ign_cnt_q <= cfg_data_i[2:0];
        ivsa_pkg::CFG_SLOT0:   slot_q[0] <= cfg_data_i;
        ivsa_pkg::CFG_SLOT1:   slot_q[1] <= cfg_data_i;
        ivsa_pkg::CFG_SLOT2:   slot_q[2] <= cfg_data_i;
        ivsa_pkg::CFG_SLOT3:   slot_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ignore list match on the one-based integration number
  always_comb begin
    ign_n   = (ign_cnt_q > 3'd4) ? 3'd4 : ign_cnt_q;
    intg_p1 = {1'b0, integration_index_i} + 9'd1;
    ignored = 1'b0;
    for (int k = 0; k < ivsa_pkg::IGN_SLOTS; k++) begin
      if ((3'(k) < ign_n) && (intg_p1 == {1'b0, slot_q[k]})) ignored = 1'b1;
    end
  end

  // classification
  always_comb begin
    item_o.pix   = pixel_index_i;
    item_o.flags = quality_flags_i;
    item_o.slope = slope_value_i;
    item_o.unc   = slope_uncertainty_i;
    priority if (nint_q <= 8'd1) begin
      item_o.op = quick_q ? ivsa_pkg::OP_COPY_Q : ivsa_pkg::OP_COPY_W;
    end else if (quick_q) begin
      item_o.op = slope_missing_i ? ivsa_pkg::OP_NOP : ivsa_pkg::OP_QADD;
    end else if (ignored) begin
      item_o.op = ivsa_pkg::OP_NOP;
    end else begin
      item_o.op = slope_missing_i ? ivsa_pkg::OP_FLAG : ivsa_pkg::OP_WADD;
    end
  end

endmodule

>>> design/ivsa_queue.sv
// Two-entry queue between front and back end.
// Depends on ivsa_pkg.
module ivsa_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ivsa_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output ivsa_pkg::item_t item_o
);

  ivsa_pkg::item_t ent_q [2];
  logic            wp_q, rp_q;
  logic [1:0]      cnt_q;

  assign full_o  = cnt_q[1];
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = ent_q[rp_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wp_q] <= item_i;
  end

endmodule

>>> design/ivsa_div.sv
// Pipelined variance and restoring division: one quotient bit per stage,
// two lanes (slope term and weight). Depends on ivsa_pkg.
module ivsa_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  ivsa_pkg::item_t                item_i,
  output logic                           valid_o,
  output ivsa_pkg::item_t                item_o,
  output logic                           vzero_o,
  output logic                           vle1_o,
  output logic [ivsa_pkg::DIV_W-1:0]     quot_o,
  output logic [ivsa_pkg::WT_W-1:0]      wquot_o
);

  localparam int N = ivsa_pkg::DIV_W;

  logic                          vld_q  [N+1];
  ivsa_pkg::item_t               itm_q  [N+1];
  logic [ivsa_pkg::SLOPE_W-1:0]  mag_q  [N+1];
  logic [ivsa_pkg::VAR_W-1:0]    var_q  [N+1];
  logic [ivsa_pkg::VAR_W-1:0]    r1_q   [N+1];
  logic [ivsa_pkg::VAR_W-1:0]    r2_q   [N+1];
  logic [N-1:0]                  q1_q   [N+1];
  logic [N-1:0]                  q2_q   [N+1];
  logic [ivsa_pkg::SLOPE_W-1:0]  mag_in;

  assign mag_in = item_i.slope[ivsa_pkg::SLOPE_W-1] ? (~item_i.slope + 32'd1) : item_i.slope;

  // variance stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q[0] <= 1'b0;
    else if (en_i) vld_q[0] <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      itm_q[0] <= item_i;
      mag_q[0] <= mag_in;
      var_q[0] <= item_i.unc * item_i.unc;
      r1_q[0]  <= '0;
      r2_q[0]  <= '0;
      q1_q[0]  <= '0;
      q2_q[0]  <= '0;
    end
  end

  // division steps, most significant dividend bit first
  for (genvar k = 0; k < N; k++) begin : g_step
    localparam int P = N - 1 - k;
    logic                         b1, b2;
    logic [ivsa_pkg::VAR_W:0]     t1, t2, s1, s2, dv;
    logic                         ge1, ge2;

    if (P >= ivsa_pkg::FRAC_B) begin : g_mag
      assign b1 = mag_q[k][P-ivsa_pkg::FRAC_B];
    end else begin : g_zero
      assign b1 = 1'b0;
    end
    assign b2 = (P == ivsa_pkg::FRAC_B);

    always_comb begin
      dv  = {1'b0, var_q[k]};
      t1  = {r1_q[k], b1};
      t2  = {r2_q[k], b2};
      ge1 = (t1 >= dv);
      ge2 = (t2 >= dv);
      s1  = ge1 ? (t1 - dv) : t1;
      s2  = ge2 ? (t2 - dv) : t2;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[k+1] <= 1'b0;
      else if (en_i) vld_q[k+1] <= vld_q[k];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        itm_q[k+1] <= itm_q[k];
        mag_q[k+1] <= mag_q[k];
        var_q[k+1] <= var_q[k];
        r1_q[k+1]  <= s1[ivsa_pkg::VAR_W-1:0];
        r2_q[k+1]  <= s2[ivsa_pkg::VAR_W-1:0];
        q1_q[k+1]  <= {q1_q[k][N-2:0], ge1};
        q2_q[k+1]  <= {q2_q[k][N-2:0], ge2};
      end
    end
  end

  assign valid_o = vld_q[N];
  assign item_o  = itm_q[N];
  assign vzero_o = (var_q[N] == '0);
  assign vle1_o  = (var_q[N] <= 64'd1);
  assign quot_o  = q1_q[N];
  assign wquot_o = q2_q[N][ivsa_pkg::WT_W-1:0];

endmodule

>>> design/ivsa_back.sv
// Back end: divider pipeline, pixel stores with read-modify-write and
// forwarding, clearing pass and output register. Depends on ivsa_pkg, ivsa_div.
module ivsa_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_valid_i,
  input  ivsa_pkg::item_t                   q_item_i,
  output logic                              pop_o,
  output logic                              clear_busy_o,
  input  logic                              out_stall_i,
  output logic                              out_valid_o,
  output logic [ivsa_pkg::PIX_W-1:0]        result_pixel_o,
  output logic signed [ivsa_pkg::WSUM_W-1:0] weighted_sum_o,
  output logic [ivsa_pkg::WT_W-1:0]         weight_sum_o,
  output logic [ivsa_pkg::FLAG_W-1:0]       merged_flags_o
);

  logic                            adv;
  logic [ivsa_pkg::ADDR_W:0]       clr_q;
  logic                            clearing;

  logic                            d_valid;
  ivsa_pkg::item_t                 d_item;
  logic                            d_vzero, d_vle1;
  logic [ivsa_pkg::DIV_W-1:0]      d_quot;
  logic [ivsa_pkg::WT_W-1:0]       d_wquot;

  logic [ivsa_pkg::WSUM_W-1:0]     term;
  logic [ivsa_pkg::WSUM_W-1:0]     qcap;
  logic [ivsa_pkg::WT_W-1:0]       wgt;

  logic                            u_valid_q;
  ivsa_pkg::item_t                 u_item_q;
  logic [ivsa_pkg::WSUM_W-1:0]     u_term_q;
  logic [ivsa_pkg::WT_W-1:0]       u_wgt_q;

  logic [ivsa_pkg::WSUM_W-1:0]     ws_mem [ivsa_pkg::PIXELS];
  logic [ivsa_pkg::WT_W-1:0]       wt_mem [ivsa_pkg::PIXELS];
  logic [ivsa_pkg::FLAG_W-1:0]     fl_mem [ivsa_pkg::PIXELS];
  logic [ivsa_pkg::WSUM_W-1:0]     rd_ws_q;
  logic [ivsa_pkg::WT_W-1:0]       rd_wt_q;
  logic [ivsa_pkg::FLAG_W-1:0]     rd_fl_q;

  logic                            lw_valid_q;
  logic [ivsa_pkg::ADDR_W-1:0]     lw_addr_q;
  logic [ivsa_pkg::WSUM_W-1:0]     lw_ws_q;
  logic [ivsa_pkg::WT_W-1:0]       lw_wt_q;
  logic [ivsa_pkg::FLAG_W-1:0]     lw_fl_q;

  logic [ivsa_pkg::ADDR_W-1:0]     u_addr;
  logic                            fwd;
  logic [ivsa_pkg::WSUM_W-1:0]     old_ws, new_ws, slope_q32, ws_addend;
  logic [ivsa_pkg::WT_W-1:0]       old_wt, new_wt, wt_addend;
  logic [ivsa_pkg::FLAG_W-1:0]     old_fl, new_fl;
  logic [ivsa_pkg::WSUM_W:0]       ws_sum;
  logic [ivsa_pkg::WT_W:0]         wt_sum;

  logic                            we;
  logic [ivsa_pkg::ADDR_W-1:0]     wa;
  logic [ivsa_pkg::WSUM_W-1:0]     wd_ws;
  logic [ivsa_pkg::WT_W-1:0]       wd_wt;
  logic [ivsa_pkg::FLAG_W-1:0]     wd_fl;

  logic                            out_valid_q;
  logic [ivsa_pkg::PIX_W-1:0]      out_pix_q;
  logic [ivsa_pkg::WSUM_W-1:0]     out_ws_q;
  logic [ivsa_pkg::WT_W-1:0]       out_wt_q;
  logic [ivsa_pkg::FLAG_W-1:0]     out_fl_q;

  // whole pipeline moves together unless the output is held
  assign adv          = !out_valid_q || !out_stall_i;
  assign clearing     = !clr_q[ivsa_pkg::ADDR_W];
  assign clear_busy_o = clearing;
  assign pop_o        = adv && q_valid_i && !clearing;

  // clearing pass counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else if (clearing) clr_q <= clr_q + 1'b1;
  end

  ivsa_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (pop_o),
    .item_i  (q_item_i),
    .valid_o (d_valid),
    .item_o  (d_item),
    .vzero_o (d_vzero),
    .vle1_o  (d_vle1),
    .quot_o  (d_quot),
    .wquot_o (d_wquot)
  );

  // slope term and weight with saturation
  always_comb begin
    if ((|d_quot[ivsa_pkg::DIV_W-1:ivsa_pkg::WSUM_W]) ||
        (d_quot[ivsa_pkg::WSUM_W-1] && (|d_quot[ivsa_pkg::WSUM_W-2:0]))) begin
      qcap = ivsa_pkg::WSUM_MIN;   // magnitude 2^63
    end else begin
      qcap = d_quot[ivsa_pkg::WSUM_W-1:0];
    end
    if (d_vzero) begin
      if (d_item.slope == '0)                          term = '0;
      else if (d_item.slope[ivsa_pkg::SLOPE_W-1])      term = ivsa_pkg::WSUM_MIN;
      else                                             term = ivsa_pkg::WSUM_MAX;
    end else if (d_item.slope[ivsa_pkg::SLOPE_W-1]) begin
      term = (qcap == ivsa_pkg::WSUM_MIN) ? ivsa_pkg::WSUM_MIN : (~qcap + 64'd1);
    end else begin
      term = qcap[ivsa_pkg::WSUM_W-1] ? ivsa_pkg::WSUM_MAX : qcap;
    end
    wgt = d_vle1 ? ivsa_pkg::WT_MAX : d_wquot;
  end

  // update stage registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) u_valid_q <= 1'b0;
    else if (adv) u_valid_q <= d_valid;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      u_item_q <= d_item;
      u_term_q <= term;
      u_wgt_q  <= wgt;
    end
  end

  // store reads, registered
  always_ff @(posedge clk_i) begin
    if (adv) begin
      rd_ws_q <= ws_mem[d_item.pix[ivsa_pkg::ADDR_W-1:0]];
      rd_wt_q <= wt_mem[d_item.pix[ivsa_pkg::ADDR_W-1:0]];
      rd_fl_q <= fl_mem[d_item.pix[ivsa_pkg::ADDR_W-1:0]];
    end
  end

  // forwarding from the latest write, then the new entry values
  always_comb begin
    u_addr    = u_item_q.pix[ivsa_pkg::ADDR_W-1:0];
    fwd       = lw_valid_q && (lw_addr_q == u_addr);
    old_ws    = fwd ? lw_ws_q : rd_ws_q;
    old_wt    = fwd ? lw_wt_q : rd_wt_q;
    old_fl    = fwd ? lw_fl_q : rd_fl_q;
    slope_q32 = {{16{u_item_q.slope[ivsa_pkg::SLOPE_W-1]}}, u_item_q.slope, 16'd0};
    ws_addend = (u_item_q.op == ivsa_pkg::OP_QADD) ? slope_q32 : u_term_q;
    wt_addend = (u_item_q.op == ivsa_pkg::OP_QADD) ? ivsa_pkg::ONE_Q16 : u_wgt_q;
    ws_sum    = {old_ws[ivsa_pkg::WSUM_W-1], old_ws} + {ws_addend[ivsa_pkg::WSUM_W-1], ws_addend};
    wt_sum    = {1'b0, old_wt} + {1'b0, wt_addend};
    new_ws    = old_ws;
    new_wt    = old_wt;
    new_fl    = old_fl;
    unique case (u_item_q.op)
      ivsa_pkg::OP_COPY_W: begin
        new_ws = slope_q32;
        new_wt = {16'd0, u_item_q.unc};
        new_fl = u_item_q.flags;
      end
      ivsa_pkg::OP_COPY_Q: new_ws = slope_q32;
      ivsa_pkg::OP_FLAG:   new_fl = old_fl | u_item_q.flags;
      ivsa_pkg::OP_QADD, ivsa_pkg::OP_WADD: begin
        if (ws_sum[ivsa_pkg::WSUM_W] != ws_sum[ivsa_pkg::WSUM_W-1]) begin
          new_ws = ws_sum[ivsa_pkg::WSUM_W] ? ivsa_pkg::WSUM_MIN : ivsa_pkg::WSUM_MAX;
        end else begin
          new_ws = ws_sum[ivsa_pkg::WSUM_W-1:0];
        end
        new_wt = wt_sum[ivsa_pkg::WT_W] ? ivsa_pkg::WT_MAX : wt_sum[ivsa_pkg::WT_W-1:0];
        if (u_item_q.op == ivsa_pkg::OP_WADD) new_fl = old_fl | u_item_q.flags;
      end
      default: ;
    endcase
  end

  // store write port: clearing pass or update
  always_comb begin
    we    = clearing || (adv && u_valid_q);
    wa    = clearing ? clr_q[ivsa_pkg::ADDR_W-1:0] : u_addr;
    wd_ws = clearing ? '0 : new_ws;
    wd_wt = clearing ? '0 : new_wt;
    wd_fl = clearing ? '0 : new_fl;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      ws_mem[wa] <= wd_ws;
      wt_mem[wa] <= wd_wt;
      fl_mem[wa] <= wd_fl;
    end
  end

  // latest write for forwarding
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) lw_valid_q <= 1'b0;
    else if (adv && u_valid_q) lw_valid_q <= 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (adv && u_valid_q) begin
      lw_addr_q <= u_addr;
      lw_ws_q   <= new_ws;
      lw_wt_q   <= new_wt;
      lw_fl_q   <= new_fl;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (adv) out_valid_q <= u_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv && u_valid_q) begin
      out_pix_q <= u_item_q.pix;
      out_ws_q  <= new_ws;
      out_wt_q  <= new_wt;
      out_fl_q  <= new_fl;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_pixel_o = out_pix_q;
  assign weighted_sum_o = out_ws_q;
  assign weight_sum_o   = out_wt_q;
  assign merged_flags_o = out_fl_q;

endmodule

>>> design/inverse_variance_slope_accumulator.sv
// Top level of the inverse variance slope accumulator.
// Depends on ivsa_pkg, ivsa_front, ivsa_queue, ivsa_back.
//
//   channel  handshake              payload
//   -------  ---------------------  ----------------------------------------------
//   cfg      cfg_we_i               cfg_idx_i, cfg_data_i
//   in       in_valid_i/in_stall_o  pixel_index, integration_index, slope_*, flags
//   out      out_valid_o/out_stall_i result_pixel, weighted_sum, weight_sum, flags
//
// One request per cycle while in_stall_o is low. A request passes the queue, the
// variance multiplier, the 80-stage restoring divider, the store update and the
// output stage. After reset a clearing pass zeroes all 65536 pixel store entries,
// one entry per cycle; in_stall_o stays high during it.
// With out_valid_o high, out_stall_i freezes the whole back pipeline;
// the two-entry queue then fills and raises in_stall_o.
module inverse_variance_slope_accumulator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ivsa_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ivsa_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [ivsa_pkg::PIX_W-1:0]          pixel_index_i,
  input  logic [ivsa_pkg::INTG_W-1:0]         integration_index_i,
  input  logic signed [ivsa_pkg::SLOPE_W-1:0] slope_value_i,
  input  logic                                slope_missing_i,
  input  logic [ivsa_pkg::UNC_W-1:0]          slope_uncertainty_i,
  input  logic [ivsa_pkg::FLAG_W-1:0]         quality_flags_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [ivsa_pkg::PIX_W-1:0]          result_pixel_o,
  output logic signed [ivsa_pkg::WSUM_W-1:0]  weighted_sum_o,
  output logic [ivsa_pkg::WT_W-1:0]           weight_sum_o,
  output logic [ivsa_pkg::FLAG_W-1:0]         merged_flags_o
);

  ivsa_pkg::item_t f_item, q_item;
  logic            q_full, q_valid, q_pop, clear_busy, push;

  assign in_stall_o = clear_busy || q_full;
  assign push       = in_valid_i && !in_stall_o;

  ivsa_front u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .pixel_index_i       (pixel_index_i),
    .integration_index_i (integration_index_i),
    .slope_value_i       (slope_value_i),
    .slope_missing_i     (slope_missing_i),
    .slope_uncertainty_i (slope_uncertainty_i),
    .quality_flags_i     (quality_flags_i),
    .item_o              (f_item)
  );

  ivsa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (f_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  ivsa_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_item_i       (q_item),
    .pop_o          (q_pop),
    .clear_busy_o   (clear_busy),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .result_pixel_o (result_pixel_o),
    .weighted_sum_o (weighted_sum_o),
    .weight_sum_o   (weight_sum_o),
    .merged_flags_o (merged_flags_o)
  );

endmodule
